// ----- sv/bdq_pkg.sv -----
// bdq_pkg: shared types and codes for the bounded deque.
// Holds the operation and status codes and the item structs; no dependencies.
package bdq_pkg;

    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]            operation;
        logic [VALUE_BITS-1:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] popped_value;
        logic [COUNT_BITS-1:0] entry_count;
    } t_out_item;

    // Result side of the control unit, aligned with the store's read data.
    typedef struct packed {
        logic                  done;
        logic                  pop_ok;
        t_status               status;
        logic [COUNT_BITS-1:0] count;
    } t_ctrl_res;

endpackage

// ----- sv/bounded_deque.sv -----
// bounded_deque: double-ended queue of DEPTH entries kept as a ring in one memory.
// Depends on bdq_pkg, bdq_ctrl and bdq_store.
//
// Usage:
//   Command channel: drive start with i_item (operation, entry_value). The item
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: o_done pulses for exactly one cycle with o_result (status,
//   popped_value, entry_count). The receiver cannot stall it; sample it then.
// Results: every item gives one result, in the cycle after it is taken.
// Throughput: one item per cycle while busy is low. The ring pointer and count
//   update in the same cycle the store is written (push) or read (pop); pop data
//   comes out of the store's registered read port in the next cycle, alongside the status.
// Operations: push front, push back, pop front, pop back. A push into a full
//   ring is refused with status full; a pop from an empty ring with status
//   empty. Refused items leave the ring untouched and return popped_value zero.
// Reset (synchronous, active low): clear head and count, drop any pending
//   result and hold busy high in the cycle after release. Memory contents are
//   not cleared; only written entries are ever read.
module bounded_deque #(
    parameter int DEPTH      = 16,
    parameter int ENTRY_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bdq_pkg::t_in_item    i_item,
    output logic                 o_done,
    output bdq_pkg::t_out_item   o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int WIDE = (ENTRY_BITS > bdq_pkg::VALUE_BITS) ? ENTRY_BITS
                                                             : bdq_pkg::VALUE_BITS;

    logic                  r_busy;
    logic                  w_accept;
    logic                  w_we, w_re;
    logic [AW-1:0]         w_addr;
    logic [WIDE-1:0]       w_wide_in, w_wide_out;
    logic [ENTRY_BITS-1:0] w_wdata, w_rdata;
    bdq_pkg::t_ctrl_res    w_res;

    // Hold off items while in reset and in the cycle after release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // Keep only ENTRY_BITS of the pushed value; pad with zeros when wider.
    assign w_wide_in = WIDE'(i_item.entry_value);
    assign w_wdata   = w_wide_in[ENTRY_BITS-1:0];

    bdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_operation (i_item.operation),
        .o_we        (w_we),
        .o_re        (w_re),
        .o_addr      (w_addr),
        .o_res       (w_res)
    );

    bdq_store #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Zero the value for pushes and refused pops.
    assign w_wide_out = WIDE'(w_rdata);

    always_comb begin
        o_done                = w_res.done;
        o_result.status       = w_res.status;
        o_result.entry_count  = w_res.count;
        o_result.popped_value = w_res.pop_ok ? w_wide_out[bdq_pkg::VALUE_BITS-1:0] : '0;
    end

    // Every accepted item gives exactly one result in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted item gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_done)
        else $error("result without an accepted item");

    // A refused push only happens with the ring full.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == bdq_pkg::ST_FULL)
            |-> (o_result.entry_count == bdq_pkg::COUNT_BITS'(DEPTH)))
        else $error("full status with ring not full");

    // A refused pop leaves an empty ring and a zero value.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == bdq_pkg::ST_EMPTY)
            |-> (o_result.entry_count == '0 && o_result.popped_value == '0))
        else $error("empty status with entries held or value returned");

endmodule

// ----- sv/bdq_store.sv -----
// bdq_store: entry memory of the deque, one write or one read per cycle.
// Read data is registered. No package dependency.
module bdq_store #(
    parameter int DEPTH      = 16,
    parameter int ENTRY_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_addr,
    input  logic [ENTRY_BITS-1:0]        i_wdata,
    output logic [ENTRY_BITS-1:0]        o_rdata
);

    logic [ENTRY_BITS-1:0] r_mem [DEPTH];
    logic [ENTRY_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bdq_ctrl.sv -----
// bdq_ctrl: head pointer and fill count of the ring, store addressing and status.
// Depends on bdq_pkg.
module bdq_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_operation,
    output logic                          o_we,
    output logic                          o_re,
    output logic [$clog2(DEPTH)-1:0]      o_addr,
    output bdq_pkg::t_ctrl_res            o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    bdq_pkg::t_ctrl_res r_res, n_res;

    bdq_pkg::t_op  w_op;
    logic          w_full, w_empty;
    logic [AW-1:0] w_head_dec, w_head_inc;
    logic [CW-1:0] w_offset;
    logic [SW-1:0] w_sum;
    logic [AW-1:0] w_pos;

    always_comb begin
        w_op       = bdq_pkg::t_op'(i_operation);
        w_full     = (r_count == CW'(DEPTH));
        w_empty    = (r_count == '0);
        w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
        w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        // Back slot for a push is head+count; last entry for a pop is head+count-1.
        w_offset   = (w_op == bdq_pkg::OP_POP_BACK) ? r_count - CW'(1) : r_count;
        w_sum      = SW'(r_head) + SW'(w_offset);
        w_pos      = (w_sum >= SW'(DEPTH)) ? AW'(w_sum - SW'(DEPTH)) : AW'(w_sum);

        n_head      = r_head;
        n_count     = r_count;
        o_we        = 1'b0;
        o_re        = 1'b0;
        o_addr      = w_pos;
        n_res       = '0;
        n_res.done  = i_accept;
        n_res.status = bdq_pkg::ST_OK;

        case (w_op)
            bdq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_res.status = bdq_pkg::ST_FULL;
                end else begin
                    o_we    = i_accept;
                    o_addr  = w_head_dec;
                    if (i_accept) begin
                        n_head  = w_head_dec;
                        n_count = r_count + CW'(1);
                    end
                end
            end
            bdq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    n_res.status = bdq_pkg::ST_FULL;
                end else begin
                    o_we = i_accept;
                    if (i_accept) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    n_res.status = bdq_pkg::ST_EMPTY;
                end else begin
                    o_re         = i_accept;
                    o_addr       = r_head;
                    n_res.pop_ok = 1'b1;
                    if (i_accept) begin
                        n_head  = w_head_inc;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    n_res.status = bdq_pkg::ST_EMPTY;
                end else begin
                    o_re         = i_accept;
                    n_res.pop_ok = 1'b1;
                    if (i_accept) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_res.status = bdq_pkg::ST_OK;
            end
        endcase

        // Count after the operation, cut to the result field.
        n_res.count = bdq_pkg::COUNT_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_res       <= '0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_res       <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- test/tb_bounded_deque.sv -----
// tb_bounded_deque: self-checking testbench for the bounded double-ended queue.
// Depends on bdq_pkg and bounded_deque; predicts every result with its own ring model.
`timescale 1ns / 100ps

module tb_bounded_deque;

    localparam int RING_DEPTH     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1925;

    // Clock, reset and ports. Start every input at a known value.
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    bdq_pkg::t_in_item  i_item  = '0;
    logic               o_done;
    bdq_pkg::t_out_item o_result;

    bounded_deque #(
        .DEPTH      (RING_DEPTH),
        .ENTRY_BITS (bdq_pkg::VALUE_BITS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // 8 ns period: high for half, low for half.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the ring, kept in step with every accepted item.
    logic [bdq_pkg::VALUE_BITS-1:0] ring_store [RING_DEPTH];
    int                             ring_head  = 0;
    int                             ring_count = 0;

    // Results the block owes us, oldest first.
    bdq_pkg::t_out_item awaited_results [$];

    int error_count    = 0;
    int items_taken    = 0;
    int results_seen   = 0;
    int full_refusals  = 0;
    int empty_refusals = 0;
    int peak_count     = 0;
    int stall_cycles   = 0;
    int burst_left     = 0;

    // Apply one operation to the shadow ring and return the result it owes.
    // Refused pushes and pops leave the ring as it was and return zero data.
    function automatic bdq_pkg::t_out_item predict_deque_result(
        bdq_pkg::t_op op, logic [bdq_pkg::VALUE_BITS-1:0] value);
        bdq_pkg::t_out_item res;
        res.status       = bdq_pkg::ST_OK;
        res.popped_value = '0;
        case (op)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                if (ring_count == RING_DEPTH) begin
                    res.status = bdq_pkg::ST_FULL;
                end else if (op == bdq_pkg::OP_PUSH_FRONT) begin
                    ring_head             = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
                    ring_store[ring_head] = value;
                    ring_count++;
                end else begin
                    ring_store[(ring_head + ring_count) % RING_DEPTH] = value;
                    ring_count++;
                end
            end
            default: begin
                if (ring_count == 0) begin
                    res.status = bdq_pkg::ST_EMPTY;
                end else if (op == bdq_pkg::OP_POP_FRONT) begin
                    res.popped_value = ring_store[ring_head];
                    ring_head        = (ring_head + 1) % RING_DEPTH;
                    ring_count--;
                end else begin
                    res.popped_value = ring_store[(ring_head + ring_count - 1) % RING_DEPTH];
                    ring_count--;
                end
            end
        endcase
        res.entry_count = bdq_pkg::COUNT_BITS'(ring_count);
        return res;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(string what, logic [bdq_pkg::VALUE_BITS-1:0] got,
                                   logic [bdq_pkg::VALUE_BITS-1:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Sample everything at the rising edge, before the block's own updates land.
    // Check the result first, then record the item taken at this same edge.
    always @(posedge i_clk) begin : result_monitor
        bdq_pkg::t_out_item want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no item outstanding", o_result.popped_value, '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_result.status != want.status)
                    report_mismatch("status", bdq_pkg::VALUE_BITS'(o_result.status),
                                    bdq_pkg::VALUE_BITS'(want.status));
                if (o_result.popped_value != want.popped_value)
                    report_mismatch("popped_value", o_result.popped_value, want.popped_value);
                if (o_result.entry_count != want.entry_count)
                    report_mismatch("entry_count", bdq_pkg::VALUE_BITS'(o_result.entry_count),
                                    bdq_pkg::VALUE_BITS'(want.entry_count));
            end
        end
        if (i_rst_n && start && !busy) begin
            want = predict_deque_result(bdq_pkg::t_op'(i_item.operation), i_item.entry_value);
            awaited_results.push_back(want);
            items_taken++;
            if (want.status == bdq_pkg::ST_FULL)  full_refusals++;
            if (want.status == bdq_pkg::ST_EMPTY) empty_refusals++;
            if (ring_count > peak_count) peak_count = ring_count;
        end
    end

    // Abort when neither side moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no item or result for %0d cycles",
                     $realtime, WATCHDOG_LIMIT);
            $display("** bounded_deque: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one item and hold it until the block takes it. At the end of a
    // burst, drop start for a random gap first, so that start is never
    // lowered and raised in the same step.
    task automatic send_item(bdq_pkg::t_op op, logic [bdq_pkg::VALUE_BITS-1:0] value);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 30);
        end
        start              <= 1'b1;
        i_item.operation   <= op;
        i_item.entry_value <= value;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        burst_left = 0;
    endtask

    // Pops on a freshly reset ring must both be refused as empty.
    task automatic test_pop_when_empty();
        send_item(bdq_pkg::OP_POP_FRONT, '1);
        send_item(bdq_pkg::OP_POP_BACK, '1);
    endtask

    // Use both ends with extreme values, then empty the ring and pop once more.
    task automatic test_both_ends();
        send_item(bdq_pkg::OP_PUSH_FRONT, '0);
        send_item(bdq_pkg::OP_PUSH_BACK, '1);
        send_item(bdq_pkg::OP_POP_BACK, '0);
        send_item(bdq_pkg::OP_POP_FRONT, '1);
        send_item(bdq_pkg::OP_POP_BACK, '0);
    endtask

    // Fill to the top from alternate ends, wrapping the head below zero,
    // then offer a push at each end: both must be refused as full.
    task automatic test_fill_to_full();
        for (int k = 0; k < RING_DEPTH; k++) begin
            send_item((k % 2) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT, $urandom());
        end
        send_item(bdq_pkg::OP_PUSH_FRONT, $urandom());
        send_item(bdq_pkg::OP_PUSH_BACK, $urandom());
    endtask

    // Random traffic in segments that lean towards filling, draining or
    // neither, so the ring swings between empty and full and wraps often.
    task automatic test_random_traffic(int n_items);
        int                             segment_left;
        int                             push_pct;
        logic [bdq_pkg::VALUE_BITS-1:0] value;
        bdq_pkg::t_op                   op;
        segment_left = 0;
        push_pct     = 50;
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2) wait_for_drain();
            if (segment_left == 0) begin
                segment_left = $urandom_range(5, 60);
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            segment_left--;
            case ($urandom_range(0, 9))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom();
            endcase
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
            send_item(op, value);
        end
    endtask

    initial begin
        // Hold reset, then release it on a rising edge.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pop_when_empty();
        test_both_ends();
        test_fill_to_full();
        wait_for_drain();
        test_random_traffic(RANDOM_ITEMS);

        // Drain, then give any stray result time to arrive and check that none is owed.
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never returned",
                            bdq_pkg::VALUE_BITS'(awaited_results.size()), '0);

        $display("Ran %0d items, checked %0d results; peak fill %0d of %0d.",
                 items_taken, results_seen, peak_count, RING_DEPTH);
        $display("Refused %0d pushes on a full ring and %0d pops on an empty one.",
                 full_refusals, empty_refusals);
        if (error_count == 0) begin
            $display("** bounded_deque: PASSED **");
        end else begin
            $display("** bounded_deque: FAILED **");
        end
        $finish;
    end

endmodule
